>>> rtl/rsac_pkg.sv
// Package for the radar sweep alarm controller.
// Holds item and result types, config struct, field widths and codes.
// No dependencies.
`default_nettype none

package rsac_pkg;

  localparam int SectorsDef = 16;

  localparam int NowW    = 32;
  localparam int DistW   = 14;
  localparam int AngleW  = 8;
  localparam int KindW   = 2;
  localparam int ScanW   = 16;
  localparam int RotW    = 10;
  localparam int CfgIdxW = 2;
  localparam int CfgDataW = 16;

  localparam int ArcDeg = 180;

  // Reset values of the configuration registers
  localparam int ScanTimeRst = 4000;
  localparam int RotTimeRst  = 20;
  localparam int NearRst     = 200;
  localparam int FarRst      = 400;

  // Configuration register indexes
  localparam logic [CfgIdxW-1:0] CFG_SCAN_TIME = 2'd0;
  localparam logic [CfgIdxW-1:0] CFG_ROT_TIME  = 2'd1;
  localparam logic [CfgIdxW-1:0] CFG_NEAR      = 2'd2;
  localparam logic [CfgIdxW-1:0] CFG_FAR       = 2'd3;

  // Item kinds
  localparam logic [KindW-1:0] KIND_TICK       = 2'd0;
  localparam logic [KindW-1:0] KIND_ACTIVATE   = 2'd1;
  localparam logic [KindW-1:0] KIND_DEACTIVATE = 2'd2;

  // Blink control codes
  localparam logic [1:0] BLINK_NONE  = 2'd0;
  localparam logic [1:0] BLINK_START = 2'd1;
  localparam logic [1:0] BLINK_STOP  = 2'd2;

  // Severe alarm report codes
  localparam logic [1:0] ALARM_NONE  = 2'd0;
  localparam logic [1:0] ALARM_RAISE = 2'd1;
  localparam logic [1:0] ALARM_CLEAR = 2'd2;

  typedef struct packed {
    logic [KindW-1:0] kind;
    logic [NowW-1:0]  now_ms;
    logic             sample_valid;
    logic [DistW-1:0] sample_mm;
  } item_t;

  typedef struct packed {
    logic [AngleW-1:0] servo_angle;
    logic              move_cmd;
    logic              enter_auto;
    logic              new_scan;
    logic              new_position;
    logic              obj_reported;
    logic [DistW-1:0]  obj_distance_mm;
    logic              flash_trigger;
    logic [1:0]        blink_control;
    logic [1:0]        alarm_report;
  } result_t;

  typedef struct packed {
    logic [ScanW-1:0] dwell_ms;
    logic [RotW-1:0]  rotate_ms;
    logic [DistW-1:0] near_mm;
    logic [DistW-1:0] far_mm;
  } cfg_t;

endpackage

`default_nettype wire

>>> rtl/rsac_cfg.sv
// Configuration registers of the radar sweep alarm controller.
// Dwell per sector is derived on write by a reciprocal multiply. Uses rsac_pkg.
`default_nettype none

module rsac_cfg #(
  parameter int SECTORS = rsac_pkg::SectorsDef
) (
  input  wire                           clk,
  input  wire                           rst_n,
  input  wire                           wr_en,
  input  wire [rsac_pkg::CfgIdxW-1:0]   wr_idx,
  input  wire [rsac_pkg::CfgDataW-1:0]  wr_data,
  output rsac_pkg::cfg_t                cfg
);

  // floor(x / SECTORS) == (x * DivMul) >> DivShift for every 16-bit x
  localparam int DivShift = rsac_pkg::ScanW + $clog2(SECTORS);
  localparam int MulW     = rsac_pkg::ScanW + 1;
  localparam int ProdW    = rsac_pkg::ScanW + MulW;
  localparam logic [MulW-1:0] DivMul =
    MulW'(((64'd1 << DivShift) + 64'(SECTORS) - 64'd1) / 64'(SECTORS));
  localparam logic [rsac_pkg::ScanW-1:0] DwellRst =
    rsac_pkg::ScanW'(rsac_pkg::ScanTimeRst / SECTORS);

  logic [rsac_pkg::ScanW-1:0] dwell_r;
  logic [rsac_pkg::RotW-1:0]  rot_r;
  logic [rsac_pkg::DistW-1:0] near_r;
  logic [rsac_pkg::DistW-1:0] far_r;
  logic [ProdW-1:0]           prod;
  logic [ProdW-1:0]           prod_sh;

  assign prod    = ProdW'(wr_data[rsac_pkg::ScanW-1:0]) * ProdW'(DivMul);
  assign prod_sh = prod >> DivShift;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dwell_r <= DwellRst;
      rot_r   <= rsac_pkg::RotW'(rsac_pkg::RotTimeRst);
      near_r  <= rsac_pkg::DistW'(rsac_pkg::NearRst);
      far_r   <= rsac_pkg::DistW'(rsac_pkg::FarRst);
    end else if (wr_en) begin
      case (wr_idx)
        rsac_pkg::CFG_SCAN_TIME: dwell_r <= prod_sh[rsac_pkg::ScanW-1:0];
        rsac_pkg::CFG_ROT_TIME:  rot_r   <= wr_data[rsac_pkg::RotW-1:0];
        rsac_pkg::CFG_NEAR:      near_r  <= wr_data[rsac_pkg::DistW-1:0];
        rsac_pkg::CFG_FAR:       far_r   <= wr_data[rsac_pkg::DistW-1:0];
        default: ;
      endcase
    end
  end

  assign cfg.dwell_ms  = dwell_r;
  assign cfg.rotate_ms = rot_r;
  assign cfg.near_mm   = near_r;
  assign cfg.far_mm    = far_r;

endmodule

`default_nettype wire

>>> rtl/rsac_in_stage.sv
// Input register of the radar sweep alarm controller.
// Holds one accepted item until the core commits it. Uses rsac_pkg.
`default_nettype none

module rsac_in_stage (
  input  wire                  clk,
  input  wire                  rst_n,
  input  wire                  in_valid,
  output logic                 in_stall,
  input  wire rsac_pkg::item_t in_item,
  input  wire                  advance,
  output logic                 item_vld,
  output rsac_pkg::item_t      item
);

  logic            vld_r;
  logic            vld_nxt;
  logic            accept;
  rsac_pkg::item_t item_r;

  assign in_stall = vld_r && !advance;
  assign accept   = in_valid && !in_stall;
  assign vld_nxt  = accept || (vld_r && !advance);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else begin
      vld_r <= vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      item_r <= in_item;
    end
  end

  assign item_vld = vld_r;
  assign item     = item_r;

endmodule

`default_nettype wire

>>> rtl/rsac_core.sv
// Sweep state machine of the radar sweep alarm controller.
// Computes one result per item and commits state when the item moves on.
// Uses rsac_pkg.
`default_nettype none

module rsac_core #(
  parameter int SECTORS = rsac_pkg::SectorsDef
) (
  input  wire                  clk,
  input  wire                  rst_n,
  input  wire                  commit,
  input  wire rsac_pkg::item_t item,
  input  wire rsac_pkg::cfg_t  cfg,
  output rsac_pkg::result_t    res
);

  localparam int CntW = $clog2(SECTORS + 2);
  localparam logic [rsac_pkg::AngleW-1:0] StepDeg =
    rsac_pkg::AngleW'(rsac_pkg::ArcDeg / SECTORS);
  localparam logic [rsac_pkg::AngleW-1:0] FirstDeg =
    rsac_pkg::AngleW'((rsac_pkg::ArcDeg / SECTORS) / 2);
  localparam logic [CntW-1:0] LastSector = CntW'(SECTORS);

  localparam logic [2:0] PH_INIT   = 3'd0;
  localparam logic [2:0] PH_START  = 3'd1;
  localparam logic [2:0] PH_MOVE   = 3'd2;
  localparam logic [2:0] PH_SETTLE = 3'd3;
  localparam logic [2:0] PH_DETECT = 3'd4;
  localparam logic [2:0] PH_TRACK  = 3'd5;

  logic [2:0]                  phase_r, phase_nxt;
  logic                        running_r, running_nxt;
  logic [CntW-1:0]             cnt_r, cnt_nxt;
  logic [rsac_pkg::AngleW-1:0] angle_r, angle_nxt;
  logic                        ats_r, ats_nxt;
  logic                        ong_r, ong_nxt;
  logic [rsac_pkg::NowW-1:0]   move_t_r, move_t_nxt;
  logic [rsac_pkg::NowW-1:0]   dwell_t_r, dwell_t_nxt;

  logic [rsac_pkg::NowW-1:0]   move_el;
  logic [rsac_pkg::NowW-1:0]   dwell_el;
  logic [CntW-1:0]             cnt_inc;
  logic                        severe;

  assign move_el  = item.now_ms - move_t_r;
  assign dwell_el = item.now_ms - dwell_t_r;
  assign cnt_inc  = cnt_r + CntW'(1);

  always_comb begin
    phase_nxt   = phase_r;
    running_nxt = running_r;
    cnt_nxt     = cnt_r;
    angle_nxt   = angle_r;
    ats_nxt     = ats_r;
    ong_nxt     = ong_r;
    move_t_nxt  = move_t_r;
    dwell_t_nxt = dwell_t_r;
    severe      = 1'b0;
    res         = '0;

    case (item.kind)
      rsac_pkg::KIND_TICK: begin
        if (running_r) begin
          case (phase_r)
            PH_INIT: begin
              res.enter_auto = 1'b1;
              ong_nxt        = 1'b0;
              phase_nxt      = PH_START;
            end
            PH_START: begin
              cnt_nxt      = CntW'(1);
              ats_nxt      = 1'b0;
              res.new_scan = 1'b1;
              angle_nxt    = FirstDeg;
              res.move_cmd = 1'b1;
              move_t_nxt   = item.now_ms;
              phase_nxt    = PH_MOVE;
            end
            PH_SETTLE: begin
              cnt_nxt = cnt_inc;
              if (cnt_inc <= LastSector) begin
                move_t_nxt   = item.now_ms;
                angle_nxt    = angle_r + StepDeg;
                res.move_cmd = 1'b1;
                phase_nxt    = PH_MOVE;
              end else begin
                // end of sweep: keep the blink only if this sweep started it
                if (ats_r) begin
                  ong_nxt = 1'b1;
                end else begin
                  if (ong_r) begin
                    res.blink_control = rsac_pkg::BLINK_STOP;
                  end
                  ong_nxt = 1'b0;
                end
                phase_nxt = PH_START;
              end
            end
            PH_MOVE: begin
              if (move_el > rsac_pkg::NowW'(cfg.rotate_ms)) begin
                res.new_position = 1'b1;
                dwell_t_nxt      = item.now_ms;
                phase_nxt        = PH_DETECT;
              end
            end
            PH_DETECT: begin
              if (item.sample_valid) begin
                res.obj_reported    = 1'b1;
                res.obj_distance_mm = item.sample_mm;
                res.flash_trigger   = 1'b1;
                if (item.sample_mm <= cfg.far_mm) begin
                  if (item.sample_mm >= cfg.near_mm) begin
                    if (!ats_r && !ong_r) begin
                      res.blink_control = rsac_pkg::BLINK_START;
                      ats_nxt           = 1'b1;
                    end
                  end else begin
                    res.alarm_report = rsac_pkg::ALARM_RAISE;
                    phase_nxt        = PH_TRACK;
                    severe           = 1'b1;
                  end
                end
              end
              // skip the dwell timer on a severe hit
              if (!severe && (dwell_el > rsac_pkg::NowW'(cfg.dwell_ms))) begin
                phase_nxt = PH_SETTLE;
              end
            end
            PH_TRACK: begin
              if (item.sample_valid) begin
                res.obj_reported    = 1'b1;
                res.obj_distance_mm = item.sample_mm;
                if (item.sample_mm >= cfg.near_mm) begin
                  res.alarm_report = rsac_pkg::ALARM_CLEAR;
                  phase_nxt        = PH_SETTLE;
                end
              end else begin
                res.alarm_report = rsac_pkg::ALARM_CLEAR;
                phase_nxt        = PH_SETTLE;
              end
            end
            default: begin
              phase_nxt = PH_INIT;
            end
          endcase
        end
      end
      rsac_pkg::KIND_ACTIVATE: begin
        running_nxt = 1'b1;
        phase_nxt   = PH_INIT;
      end
      rsac_pkg::KIND_DEACTIVATE: begin
        running_nxt       = 1'b0;
        res.blink_control = rsac_pkg::BLINK_STOP;
      end
      default: ;
    endcase

    res.servo_angle = angle_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r   <= PH_INIT;
      running_r <= 1'b0;
      cnt_r     <= '0;
      angle_r   <= '0;
      ats_r     <= 1'b0;
      ong_r     <= 1'b0;
      move_t_r  <= '0;
      dwell_t_r <= '0;
    end else if (commit) begin
      phase_r   <= phase_nxt;
      running_r <= running_nxt;
      cnt_r     <= cnt_nxt;
      angle_r   <= angle_nxt;
      ats_r     <= ats_nxt;
      ong_r     <= ong_nxt;
      move_t_r  <= move_t_nxt;
      dwell_t_r <= dwell_t_nxt;
    end
  end

endmodule

`default_nettype wire

>>> rtl/rsac_out_stage.sv
// Result register of the radar sweep alarm controller.
// Holds one result until the receiver takes it. Uses rsac_pkg.
`default_nettype none

module rsac_out_stage (
  input  wire                    clk,
  input  wire                    rst_n,
  input  wire                    res_vld,
  input  wire rsac_pkg::result_t res,
  output logic                   advance,
  output logic                   out_valid,
  input  wire                    out_stall,
  output rsac_pkg::result_t      out_res
);

  logic              vld_r;
  logic              vld_nxt;
  rsac_pkg::result_t res_r;

  // take a new result when the register is empty or being drained
  assign advance = res_vld && (!vld_r || !out_stall);
  assign vld_nxt = advance || (vld_r && out_stall);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else begin
      vld_r <= vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      res_r <= res;
    end
  end

  assign out_valid = vld_r;
  assign out_res   = res_r;

endmodule

`default_nettype wire

>>> rtl/radar_sweep_alarm_controller.sv
// Top level of the radar sweep alarm controller.
// Ties config registers, input register, sweep core and result register.
// Uses rsac_pkg, rsac_cfg, rsac_in_stage, rsac_core, rsac_out_stage.
//
//   channel  direction  handshake             payload
//   in_      input      in_valid / in_stall   kind, now_ms, sample_valid, sample_mm
//   out_     output     out_valid / out_stall servo_angle ... alarm_report
//   cfg_     input      cfg_valid / cfg_ready cfg_index, cfg_data
//
// One item per cycle sustained while out_stall is low; a result reaches the
// outputs through the input register and then the result register, and the
// core logic sits between them.
// Reset clears both valid flags and the sweep state and loads the register
// defaults; cfg_ready is always high.
// A stalled result holds; in_stall rises only when both registers are full
// and the result is stalled.
`default_nettype none

module radar_sweep_alarm_controller #(
  parameter int SECTORS = rsac_pkg::SectorsDef
) (
  input  wire                          clk,
  input  wire                          rst_n,
  input  wire                          in_valid,
  output logic                         in_stall,
  input  wire [rsac_pkg::KindW-1:0]    in_kind,
  input  wire [rsac_pkg::NowW-1:0]     in_now_ms,
  input  wire                          in_sample_valid,
  input  wire [rsac_pkg::DistW-1:0]    in_sample_mm,
  output logic                         out_valid,
  input  wire                          out_stall,
  output logic [rsac_pkg::AngleW-1:0]  out_servo_angle,
  output logic                         out_move_cmd,
  output logic                         out_enter_auto,
  output logic                         out_new_scan,
  output logic                         out_new_position,
  output logic                         out_obj_reported,
  output logic [rsac_pkg::DistW-1:0]   out_obj_distance_mm,
  output logic                         out_flash_trigger,
  output logic [1:0]                   out_blink_control,
  output logic [1:0]                   out_alarm_report,
  input  wire                          cfg_valid,
  output logic                         cfg_ready,
  input  wire [rsac_pkg::CfgIdxW-1:0]  cfg_index,
  input  wire [rsac_pkg::CfgDataW-1:0] cfg_data
);

  rsac_pkg::item_t   in_item;
  rsac_pkg::item_t   item;
  rsac_pkg::cfg_t    cfg;
  rsac_pkg::result_t res;
  rsac_pkg::result_t out_res;
  logic              item_vld;
  logic              advance;

  assign cfg_ready = 1'b1;

  assign in_item.kind         = in_kind;
  assign in_item.now_ms       = in_now_ms;
  assign in_item.sample_valid = in_sample_valid;
  assign in_item.sample_mm    = in_sample_mm;

  rsac_cfg #(.SECTORS(SECTORS)) u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr_en   (cfg_valid && cfg_ready),
    .wr_idx  (cfg_index),
    .wr_data (cfg_data),
    .cfg     (cfg)
  );

  rsac_in_stage u_in (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_item  (in_item),
    .advance  (advance),
    .item_vld (item_vld),
    .item     (item)
  );

  rsac_core #(.SECTORS(SECTORS)) u_core (
    .clk    (clk),
    .rst_n  (rst_n),
    .commit (advance),
    .item   (item),
    .cfg    (cfg),
    .res    (res)
  );

  rsac_out_stage u_out (
    .clk       (clk),
    .rst_n     (rst_n),
    .res_vld   (item_vld),
    .res       (res),
    .advance   (advance),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_res   (out_res)
  );

  assign out_servo_angle     = out_res.servo_angle;
  assign out_move_cmd        = out_res.move_cmd;
  assign out_enter_auto      = out_res.enter_auto;
  assign out_new_scan        = out_res.new_scan;
  assign out_new_position    = out_res.new_position;
  assign out_obj_reported    = out_res.obj_reported;
  assign out_obj_distance_mm = out_res.obj_distance_mm;
  assign out_flash_trigger   = out_res.flash_trigger;
  assign out_blink_control   = out_res.blink_control;
  assign out_alarm_report    = out_res.alarm_report;

  // Entering auto mode reports no move, new position, object or new scan
  a_auto_alone: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_enter_auto |->
      !out_move_cmd && !out_new_position && !out_obj_reported && !out_new_scan)
    else $error("enter_auto combined with other events");

  // Distance is zero unless an object is reported
  a_dist_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_obj_reported |-> out_obj_distance_mm == '0)
    else $error("distance without object report");

  // A severe alarm is raised only on a flashed object report
  a_raise_obj: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_alarm_report == rsac_pkg::ALARM_RAISE) |->
      out_obj_reported && out_flash_trigger)
    else $error("severe alarm raised without object");

  // The core never commits without a pending item
  a_commit_item: assert property (@(posedge clk) disable iff (!rst_n)
    advance |-> item_vld)
    else $error("commit without item");

endmodule

`default_nettype wire

>>> verif/radar_sweep_alarm_controller_tb.sv
// Self-checking testbench for the radar sweep alarm controller.
// Runs a directed table and then random sweeps under several idling modes.
// Depends on rsac_pkg and radar_sweep_alarm_controller.
`default_nettype none

module radar_sweep_alarm_controller_tb;
  import rsac_pkg::*;

  localparam int SECTORS     = SectorsDef;
  localparam int STEP_DEG    = ArcDeg / SECTORS;
  localparam logic [31:0] SECTOR_DIV = SECTORS;
  localparam int CYCLE_LIMIT = 300000;
  localparam int PHASES      = 8;
  localparam int PHASE_ITEMS = 215;
  localparam logic [KindW-1:0] KIND_UNKNOWN = 2'd3;

  typedef enum logic [2:0] {
    SW_INIT, SW_START, SW_MOVE, SW_SETTLE, SW_DETECT, SW_TRACK
  } sweep_ph_t;

  typedef struct {
    item_t   it;
    bit      typed;
    result_t res;
  } dir_row_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic [KindW-1:0] in_kind = '0;
  logic [NowW-1:0] in_now_ms = '0;
  logic in_sample_valid = 1'b0;
  logic [DistW-1:0] in_sample_mm = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic [AngleW-1:0] out_servo_angle;
  logic out_move_cmd, out_enter_auto, out_new_scan, out_new_position;
  logic out_obj_reported, out_flash_trigger;
  logic [DistW-1:0] out_obj_distance_mm;
  logic [1:0] out_blink_control, out_alarm_report;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [CfgIdxW-1:0] cfg_index = '0;
  logic [CfgDataW-1:0] cfg_data = '0;

  // sweep model state and register shadows
  sweep_ph_t sw_ph;
  bit sw_running, scan_alarm, alarm_held;
  logic [5:0] sector_no;
  logic [7:0] angle_deg;
  logic [31:0] move_t0, dwell_t0;
  logic [ScanW-1:0] scan_ms;
  logic [RotW-1:0] rot_ms;
  logic [DistW-1:0] near_mm, far_mm;

  result_t sweep_result_q[$];
  dir_row_t dir_q[$];
  result_t want, typed_res;
  item_t it;
  int err_cnt = 0;
  int cycle_cnt = 0;
  int snd_pct = 0;
  int rcv_pct = 0;
  int n, p, roll, span;
  logic [31:0] now_cur;

  radar_sweep_alarm_controller #(.SECTORS(SECTORS)) u_top (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall),
    .in_kind(in_kind), .in_now_ms(in_now_ms),
    .in_sample_valid(in_sample_valid), .in_sample_mm(in_sample_mm),
    .out_valid(out_valid), .out_stall(out_stall),
    .out_servo_angle(out_servo_angle), .out_move_cmd(out_move_cmd),
    .out_enter_auto(out_enter_auto), .out_new_scan(out_new_scan),
    .out_new_position(out_new_position), .out_obj_reported(out_obj_reported),
    .out_obj_distance_mm(out_obj_distance_mm), .out_flash_trigger(out_flash_trigger),
    .out_blink_control(out_blink_control), .out_alarm_report(out_alarm_report),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_cnt++;
    if (cycle_cnt > CYCLE_LIMIT) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  task automatic report_mismatch(input string msg);
    $display("MISMATCH @%0t: %s", $realtime, msg);
    err_cnt++;
  endtask

  task automatic predict_sweep(input item_t x, output result_t r);
    logic [31:0] elapsed;
    bit raised;
    r = '0;
    raised = 1'b0;
    case (x.kind)
      KIND_TICK: if (sw_running) begin
        case (sw_ph)
          SW_INIT: begin
            r.enter_auto = 1'b1;
            alarm_held = 1'b0;
            sw_ph = SW_START;
          end
          SW_START: begin
            sector_no = 6'd1;
            scan_alarm = 1'b0;
            r.new_scan = 1'b1;
            angle_deg = 8'(STEP_DEG / 2);
            r.move_cmd = 1'b1;
            move_t0 = x.now_ms;
            sw_ph = SW_MOVE;
          end
          SW_SETTLE: begin
            sector_no = sector_no + 6'd1;
            if (int'(sector_no) <= SECTORS) begin
              move_t0 = x.now_ms;
              angle_deg = angle_deg + 8'(STEP_DEG);
              r.move_cmd = 1'b1;
              sw_ph = SW_MOVE;
            end else begin
              // end of sweep: carry the pre-alarm over or stop the blink
              if (scan_alarm) begin
                alarm_held = 1'b1;
              end else begin
                if (alarm_held) r.blink_control = BLINK_STOP;
                alarm_held = 1'b0;
              end
              sw_ph = SW_START;
            end
          end
          SW_MOVE: begin
            elapsed = x.now_ms - move_t0;
            if (elapsed > 32'(rot_ms)) begin
              r.new_position = 1'b1;
              dwell_t0 = x.now_ms;
              sw_ph = SW_DETECT;
            end
          end
          SW_DETECT: begin
            if (x.sample_valid) begin
              r.obj_reported = 1'b1;
              r.obj_distance_mm = x.sample_mm;
              r.flash_trigger = 1'b1;
              if (x.sample_mm <= far_mm) begin
                if (x.sample_mm >= near_mm) begin
                  if (!scan_alarm && !alarm_held) begin
                    r.blink_control = BLINK_START;
                    scan_alarm = 1'b1;
                  end
                end else begin
                  r.alarm_report = ALARM_RAISE;
                  sw_ph = SW_TRACK;
                  raised = 1'b1;
                end
              end
            end
            // skip the dwell timer on a severe detection
            elapsed = x.now_ms - dwell_t0;
            if (!raised && elapsed > 32'(scan_ms) / SECTOR_DIV) sw_ph = SW_SETTLE;
          end
          SW_TRACK: begin
            if (x.sample_valid) begin
              r.obj_reported = 1'b1;
              r.obj_distance_mm = x.sample_mm;
              if (x.sample_mm >= near_mm) begin
                r.alarm_report = ALARM_CLEAR;
                sw_ph = SW_SETTLE;
              end
            end else begin
              r.alarm_report = ALARM_CLEAR;
              sw_ph = SW_SETTLE;
            end
          end
          default: sw_ph = SW_INIT;
        endcase
      end
      KIND_ACTIVATE: begin
        sw_running = 1'b1;
        sw_ph = SW_INIT;
      end
      KIND_DEACTIVATE: begin
        sw_running = 1'b0;
        r.blink_control = BLINK_STOP;
      end
      default: ;
    endcase
    r.servo_angle = angle_deg;
  endtask

  // Entered at a falling edge, returns at the falling edge after acceptance.
  task automatic send_item(input item_t x, input bit typed, input result_t tres);
    result_t r;
    while ($urandom_range(0, 99) < snd_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_kind <= x.kind;
    in_now_ms <= x.now_ms;
    in_sample_valid <= x.sample_valid;
    in_sample_mm <= x.sample_mm;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    predict_sweep(x, r);
    sweep_result_q.push_back(typed ? tres : r);
    @(negedge clk);
  endtask

  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [CfgDataW-1:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    case (idx)
      CFG_SCAN_TIME: scan_ms = val;
      CFG_ROT_TIME:  rot_ms = val[RotW-1:0];
      CFG_NEAR:      near_mm = val[DistW-1:0];
      default:       far_mm = val[DistW-1:0];
    endcase
    @(negedge clk);
  endtask

  task automatic load_config(input int s, input int r, input int nr, input int fr);
    write_reg(CFG_SCAN_TIME, CfgDataW'(s));
    write_reg(CFG_ROT_TIME, CfgDataW'(r));
    write_reg(CFG_NEAR, CfgDataW'(nr));
    write_reg(CFG_FAR, CfgDataW'(fr));
    cfg_valid <= 1'b0;
  endtask

  task automatic add_row(input logic [KindW-1:0] k, input logic [31:0] t, input bit sv,
                         input logic [DistW-1:0] mm, input bit typed, input result_t r);
    dir_row_t row;
    row.it.kind = k;
    row.it.now_ms = t;
    row.it.sample_valid = sv;
    row.it.sample_mm = mm;
    row.typed = typed;
    row.res = r;
    dir_q.push_back(row);
  endtask

  // Distances spread over the zones set by the current limits.
  function automatic logic [DistW-1:0] pick_mm();
    int sel;
    sel = $urandom_range(0, 4);
    case (sel)
      0: return DistW'($urandom_range(0, 16383));
      1: return DistW'($urandom_range(0, near_mm));
      2: return DistW'($urandom_range(near_mm, far_mm));
      3: begin
        case ($urandom_range(0, 5))
          0: return near_mm;
          1: return far_mm;
          2: return far_mm + 1'b1;
          3: return near_mm - 1'b1;
          4: return '1;
          default: return '0;
        endcase
      end
      default: return DistW'($urandom_range(far_mm, 16383));
    endcase
  endfunction

  always @(negedge clk) out_stall <= ($urandom_range(0, 99) < rcv_pct);

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      if (sweep_result_q.size() == 0) begin
        report_mismatch("result with nothing expected");
      end else begin
        want = sweep_result_q.pop_front();
        if (out_servo_angle !== want.servo_angle)
          report_mismatch($sformatf("servo_angle %0d, want %0d", out_servo_angle,
                                    want.servo_angle));
        if (out_move_cmd !== want.move_cmd)
          report_mismatch($sformatf("move_cmd %b, want %b", out_move_cmd, want.move_cmd));
        if (out_enter_auto !== want.enter_auto)
          report_mismatch($sformatf("enter_auto %b, want %b", out_enter_auto,
                                    want.enter_auto));
        if (out_new_scan !== want.new_scan)
          report_mismatch($sformatf("new_scan %b, want %b", out_new_scan, want.new_scan));
        if (out_new_position !== want.new_position)
          report_mismatch($sformatf("new_position %b, want %b", out_new_position,
                                    want.new_position));
        if (out_obj_reported !== want.obj_reported)
          report_mismatch($sformatf("obj_reported %b, want %b", out_obj_reported,
                                    want.obj_reported));
        if (out_obj_distance_mm !== want.obj_distance_mm)
          report_mismatch($sformatf("obj_distance_mm %0d, want %0d", out_obj_distance_mm,
                                    want.obj_distance_mm));
        if (out_flash_trigger !== want.flash_trigger)
          report_mismatch($sformatf("flash_trigger %b, want %b", out_flash_trigger,
                                    want.flash_trigger));
        if (out_blink_control !== want.blink_control)
          report_mismatch($sformatf("blink_control %0d, want %0d", out_blink_control,
                                    want.blink_control));
        if (out_alarm_report !== want.alarm_report)
          report_mismatch($sformatf("alarm_report %0d, want %0d", out_alarm_report,
                                    want.alarm_report));
      end
    end
  end

  initial begin
    scan_ms = ScanW'(ScanTimeRst);
    rot_ms = RotW'(RotTimeRst);
    near_mm = DistW'(NearRst);
    far_mm = DistW'(FarRst);
    sw_ph = SW_INIT;
    sw_running = 1'b0;
    scan_alarm = 1'b0;
    alarm_held = 1'b0;
    sector_no = '0;
    angle_deg = '0;
    move_t0 = '0;
    dwell_t0 = '0;

    // directed table under the reset register values
    typed_res = '0;
    add_row(KIND_TICK, 32'hFFFF_FFFF, 1'b1, '1, 1'b1, typed_res);  // inactive tick
    add_row(KIND_UNKNOWN, 32'd7, 1'b1, 14'd100, 1'b1, typed_res);
    typed_res.blink_control = BLINK_STOP;
    add_row(KIND_DEACTIVATE, 32'd0, 1'b0, '0, 1'b1, typed_res);
    typed_res = '0;
    add_row(KIND_ACTIVATE, 32'd0, 1'b0, '0, 1'b1, typed_res);
    typed_res.enter_auto = 1'b1;
    add_row(KIND_TICK, 32'd0, 1'b0, '0, 1'b1, typed_res);
    typed_res = '0;
    typed_res.servo_angle = 8'(STEP_DEG / 2);
    typed_res.new_scan = 1'b1;
    typed_res.move_cmd = 1'b1;
    add_row(KIND_TICK, 32'd100, 1'b0, '0, 1'b1, typed_res);
    typed_res = '0;
    add_row(KIND_TICK, 32'd110, 1'b0, '0, 1'b0, typed_res);
    add_row(KIND_TICK, 32'd120, 1'b1, 14'd50, 1'b0, typed_res);   // elapsed equals allowance
    add_row(KIND_TICK, 32'd121, 1'b0, '0, 1'b0, typed_res);
    add_row(KIND_TICK, 32'd130, 1'b1, 14'd300, 1'b0, typed_res);  // pre-alarm blink
    add_row(KIND_TICK, 32'd140, 1'b1, 14'd400, 1'b0, typed_res);
    add_row(KIND_TICK, 32'd150, 1'b1, 14'd401, 1'b0, typed_res);
    add_row(KIND_TICK, 32'd160, 1'b1, 14'h3FFF, 1'b0, typed_res);
    add_row(KIND_TICK, 32'd170, 1'b1, 14'd200, 1'b0, typed_res);
    add_row(KIND_TICK, 32'd180, 1'b1, 14'd199, 1'b0, typed_res);  // severe raise
    add_row(KIND_TICK, 32'd190, 1'b1, 14'd0, 1'b0, typed_res);
    add_row(KIND_TICK, 32'd200, 1'b0, 14'd0, 1'b0, typed_res);    // object gone
    add_row(KIND_TICK, 32'hFFFF_FFF0, 1'b0, '0, 1'b0, typed_res);
    add_row(KIND_TICK, 32'd5, 1'b0, '0, 1'b0, typed_res);         // time wrap
    add_row(KIND_TICK, 32'd255, 1'b0, '0, 1'b0, typed_res);
    add_row(KIND_TICK, 32'd256, 1'b0, '0, 1'b0, typed_res);
    add_row(KIND_DEACTIVATE, 32'd300, 1'b1, 14'd10, 1'b0, typed_res);
    add_row(KIND_TICK, 32'd310, 1'b1, 14'd10, 1'b0, typed_res);
    add_row(KIND_ACTIVATE, 32'd320, 1'b0, '0, 1'b0, typed_res);
    add_row(KIND_TICK, 32'd330, 1'b0, '0, 1'b0, typed_res);

    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    foreach (dir_q[i]) send_item(dir_q[i].it, dir_q[i].typed, dir_q[i].res);
    in_valid <= 1'b0;
    @(negedge clk);

    for (p = 0; p < PHASES; p++) begin
      while (sweep_result_q.size() != 0) @(negedge clk);
      case (p)
        0: ;
        1: load_config(0, 0, 0, 0);
        2: load_config(65535, 1023, 16383, 16383);
        3: load_config(ScanTimeRst, RotTimeRst, NearRst, FarRst);
        default: begin
          if ($urandom_range(0, 1)) begin
            load_config($urandom_range(0, 65535), $urandom_range(0, 1023),
                        $urandom_range(0, 16383), $urandom_range(0, 16383));
          end else begin
            roll = $urandom_range(0, 8000);
            load_config($urandom_range(0, 4000), $urandom_range(0, 100), roll,
                        $urandom_range(roll, 16383));
          end
        end
      endcase
      case (p % 4)
        0: begin snd_pct = 0;  rcv_pct = 0;  end
        1: begin snd_pct = 75; rcv_pct = 0;  end
        2: begin snd_pct = 0;  rcv_pct = 75; end
        default: begin snd_pct = 35; rcv_pct = 35; end
      endcase
      span = (32'(rot_ms) > 32'(scan_ms) / SECTOR_DIV) ? int'(rot_ms)
                                                    : int'(32'(scan_ms) / SECTOR_DIV);
      now_cur = (p == 4) ? 32'hFFFF_FF00 : $urandom;
      n = 0;
      while (n < PHASE_ITEMS) begin
        roll = $urandom_range(0, 199);
        if (!sw_running && roll < 60) it.kind = KIND_ACTIVATE;
        else if (roll < 3) it.kind = KIND_DEACTIVATE;
        else if (roll < 6) it.kind = KIND_ACTIVATE;
        else if (roll < 8) it.kind = KIND_UNKNOWN;
        else it.kind = KIND_TICK;
        if (it.kind == KIND_TICK) begin
          // mostly short steps so the timers expire within a few ticks
          if ($urandom_range(0, 63) == 0) now_cur = $urandom;
          else now_cur = now_cur + $urandom_range(0, span / 2 + 2);
          it.now_ms = now_cur;
        end else begin
          it.now_ms = $urandom;
        end
        it.sample_valid = 1'($urandom_range(0, 1));
        it.sample_mm = it.sample_valid ? pick_mm() : DistW'($urandom_range(0, 16383));
        // ignored items do not count toward the phase
        if (!((it.kind == KIND_TICK && !sw_running) || it.kind == KIND_UNKNOWN)) n++;
        send_item(it, 1'b0, '0);
      end
      in_valid <= 1'b0;
      @(negedge clk);
    end

    while (sweep_result_q.size() != 0) @(negedge clk);
    repeat (8) @(negedge clk);
    if (err_cnt == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

`default_nettype wire
